// File: sv/avc_pkg.sv
// ----------------------------------------------------------------------------
// avc_pkg - shared types and constants for approx_vertex_cover
// Sizes of the vertex index, counters and adjacency matrix.
// ----------------------------------------------------------------------------
package avc_pkg;

    localparam int MaxVerts = 32;
    localparam int VertW    = $clog2(MaxVerts);
    localparam int CfgW     = 6;
    localparam int SizeW    = 6;
    localparam int PickW    = 5;

    localparam logic [PickW-1:0] PickMax = {PickW{1'b1}};

    typedef logic [VertW-1:0]    t_vert;
    typedef logic [MaxVerts-1:0] t_row;

endpackage

// File: sv/approx_vertex_cover.sv
// ----------------------------------------------------------------------------
// approx_vertex_cover - greedy maximal-matching vertex cover
// Stores an undirected graph edge by edge in an adjacency bit matrix; the
// last edge starts a sequencer that picks edges until none remain and
// reports the cover mask, cover size and picked edge count.
// ----------------------------------------------------------------------------
// channel   signals                                       handshake
// edge in   i_edge_u, i_edge_v, i_last_edge               i_start & !o_busy
// result    o_cover_mask, o_cover_size, o_picked_edges    o_done (1 cycle)
// config    i_cfg_data                                    i_cfg_valid & o_cfg_ready
//
// An edge without the last mark is stored in the matrix; busy stays low.
// The last edge starts the picks (at most 32 with self-loops), each of
// which runs find row, find column, drop both vertices, all through one
// priority encoder pair. The matrix is empty when the result goes out,
// so no clearing pass is needed. Reset is synchronous; the result strobe
// cannot be stalled.
// ----------------------------------------------------------------------------
module approx_vertex_cover (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  avc_pkg::t_vert            i_edge_u,
    input  avc_pkg::t_vert            i_edge_v,
    input  logic                      i_last_edge,
    output logic                      o_done,
    output logic [31:0]               o_cover_mask,
    output logic [avc_pkg::SizeW-1:0] o_cover_size,
    output logic [avc_pkg::PickW-1:0] o_picked_edges,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [avc_pkg::CfgW-1:0]  i_cfg_data
);
    import avc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_PICK,
        S_DROP
    } t_state;

    function automatic t_vert f_highest(input t_row bits);
        t_vert idx;
        idx = '0;
        for (int i = 0; i < MaxVerts; i++) begin
            if (bits[i]) idx = t_vert'(i);
        end
        return idx;
    endfunction

    function automatic t_vert f_lowest(input t_row bits);
        t_vert idx;
        idx = '0;
        for (int i = MaxVerts - 1; i >= 0; i--) begin
            if (bits[i]) idx = t_vert'(i);
        end
        return idx;
    endfunction

    t_state            r_state;
    t_row              r_adj [MaxVerts];
    t_vert             r_u;
    t_vert             r_v;
    t_row              r_cover;
    logic [SizeW-1:0]  r_size;
    logic [PickW-1:0]  r_pick;
    logic [CfgW-1:0]   r_vcount;
    logic              r_done;
    logic [31:0]       r_mask_out;
    logic [SizeW-1:0]  r_size_out;
    logic [PickW-1:0]  r_pick_out;

    t_row              row_live;
    logic              accept;
    logic              edge_ok;
    t_row              drop_keep;

    assign accept  = i_start && (r_state == S_IDLE);
    assign edge_ok = ({1'b0, i_edge_u} < r_vcount) && ({1'b0, i_edge_v} < r_vcount);

    always_comb begin
        for (int r = 0; r < MaxVerts; r++) begin
            row_live[r] = |r_adj[r];
        end
        drop_keep = ~((t_row'(1) << r_u) | (t_row'(1) << r_v));
    end

    // adjacency matrix: store on load, drop both endpoints of each pick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MaxVerts; r++) r_adj[r] <= '0;
        end else if (accept && edge_ok) begin
            r_adj[i_edge_u] <= r_adj[i_edge_u] | (t_row'(1) << i_edge_v);
            r_adj[i_edge_v] <= r_adj[i_edge_v] | (t_row'(1) << i_edge_u);
            if (i_edge_u == i_edge_v) begin
                r_adj[i_edge_u] <= r_adj[i_edge_u] | (t_row'(1) << i_edge_u);
            end
        end else if (r_state == S_DROP) begin
            for (int r = 0; r < MaxVerts; r++) begin
                if (t_vert'(r) == r_u || t_vert'(r) == r_v) begin
                    r_adj[r] <= '0;
                end else begin
                    r_adj[r] <= r_adj[r] & drop_keep;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cover    <= '0;
            r_size     <= '0;
            r_pick     <= '0;
            r_vcount   <= CfgW'(MaxVerts);
            r_done     <= 1'b0;
            r_u        <= '0;
            r_v        <= '0;
            r_mask_out <= '0;
            r_size_out <= '0;
            r_pick_out <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_vcount <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (accept && i_last_edge) r_state <= S_FIND;
                end
                S_FIND: begin
                    if (row_live == '0) begin
                        r_done     <= 1'b1;
                        r_mask_out <= 32'(r_cover);
                        r_size_out <= r_size;
                        r_pick_out <= r_pick;
                        r_cover    <= '0;
                        r_size     <= '0;
                        r_pick     <= '0;
                        r_state    <= S_IDLE;
                    end else begin
                        r_u     <= f_highest(row_live);
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_v     <= f_lowest(r_adj[r_u]);
                    r_state <= S_DROP;
                end
                S_DROP: begin
                    r_cover <= r_cover | (t_row'(1) << r_u) | (t_row'(1) << r_v);
                    r_size  <= r_size + ((r_u == r_v) ? SizeW'(1) : SizeW'(2));
                    if (r_pick != PickMax) r_pick <= r_pick + PickW'(1);
                    r_state <= S_FIND;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE);
    assign o_done         = r_done;
    assign o_cover_mask   = r_mask_out;
    assign o_cover_size   = r_size_out;
    assign o_picked_edges = r_pick_out;

endmodule

// File: sv/avc_checker.sv
// ----------------------------------------------------------------------------
// avc_checker - port-level checks for approx_vertex_cover
// Watches the edge, result and busy ports over time.
// ----------------------------------------------------------------------------
module avc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_start,
    input logic                      o_busy,
    input logic                      i_last_edge,
    input logic                      o_done,
    input logic [31:0]               o_cover_mask,
    input logic [avc_pkg::SizeW-1:0] o_cover_size,
    input logic [avc_pkg::PickW-1:0] o_picked_edges
);
    import avc_pkg::*;

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_last_edge) |=> o_busy)
        else $error("last edge transaction did not start computation");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(o_busy) && !o_busy))
        else $error("result without a preceding computation");

    a_size_popcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($countones(o_cover_mask) == int'(o_cover_size)))
        else $error("cover size does not match cover mask");

    a_size_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (({1'b0, o_picked_edges} <= o_cover_size) &&
                    ({1'b0, o_cover_size} <= {1'b0, o_picked_edges, 1'b0})))
        else $error("cover size out of range for picked edge count");

endmodule

bind approx_vertex_cover avc_checker u_avc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .i_last_edge    (i_last_edge),
    .o_done         (o_done),
    .o_cover_mask   (o_cover_mask),
    .o_cover_size   (o_cover_size),
    .o_picked_edges (o_picked_edges)
);
